>>> src/hdgp_pkg.sv
package hdgp_pkg;

    localparam int COL_W     = 5;
    localparam int ROW_W     = 5;
    localparam int RAD_W     = 6;
    localparam int TYPE_IN_W = 4;
    localparam int CNT_W     = 11;
    localparam int COORD_W   = 9;

    localparam logic [RAD_W-1:0] RADIUS_MAX = RAD_W'(32);
    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic [0:0] {
        MODE_READ  = 1'b0,
        MODE_PAINT = 1'b1
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_PAINT = 4'b1000
    } state_t;

    // ring sides in walk order, starting at the top cell of a ring
    typedef enum logic [2:0] {
        SIDE_0 = 3'd0,
        SIDE_1 = 3'd1,
        SIDE_2 = 3'd2,
        SIDE_3 = 3'd3,
        SIDE_4 = 3'd4,
        SIDE_5 = 3'd5
    } side_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row2;
    } coord_t;

    typedef struct packed {
        logic  restart;
        side_t side;
    } step_ctl_t;

endpackage

>>> src/hdgp_if.sv
interface hdgp_req_if import hdgp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [COL_W-1:0]     center_col;
    logic [ROW_W-1:0]     center_row;
    logic [RAD_W-1:0]     radius;
    logic [TYPE_IN_W-1:0] cell_type;

    modport source (output valid, mode, center_col, center_row, radius, cell_type,
                    input ready);
    modport sink   (input valid, mode, center_col, center_row, radius, cell_type,
                    output ready);
endinterface

interface hdgp_rsp_if import hdgp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TYPE_IN_W-1:0] read_value;
    logic [CNT_W-1:0]     cells_written;

    modport source (output valid, read_value, cells_written, input ready);
    modport sink   (input valid, read_value, cells_written, output ready);
endinterface

>>> src/hdgp_grid_mem.sv
module hdgp_grid_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/hdgp_step_unit.sv
module hdgp_step_unit import hdgp_pkg::*; #(
    parameter int GRID_SIZE = 32,
    parameter int ADDR_W    = 10
) (
    input  coord_t            pos,
    input  coord_t            origin,
    input  step_ctl_t         ctl,
    output coord_t            nxt,
    output logic              in_grid,
    output logic [ADDR_W-1:0] addr
);

    localparam logic signed [COORD_W-1:0] GRID_S = COORD_W'(GRID_SIZE);

    coord_t                    base;
    logic signed [COORD_W-1:0] dc;
    logic signed [COORD_W-1:0] dr;
    logic signed [COORD_W-1:0] row;

    always_comb
    begin
        base = ctl.restart ? origin : pos;
        case (ctl.side)
            SIDE_0:
            begin
                dc = COORD_W'(1);
                dr = COORD_W'(1);
            end
            SIDE_1:
            begin
                dc = COORD_W'(0);
                dr = COORD_W'(2);
            end
            SIDE_2:
            begin
                dc = -COORD_W'(1);
                dr = COORD_W'(1);
            end
            SIDE_3:
            begin
                dc = -COORD_W'(1);
                dr = -COORD_W'(1);
            end
            SIDE_4:
            begin
                dc = COORD_W'(0);
                dr = -COORD_W'(2);
            end
            SIDE_5:
            begin
                dc = COORD_W'(1);
                dr = -COORD_W'(1);
            end
            default:
            begin
                dc = COORD_W'(0);
                dr = COORD_W'(0);
            end
        endcase
        // next ring starts two half-rows above the previous start
        if (ctl.restart)
        begin
            dc = COORD_W'(0);
            dr = -COORD_W'(2);
        end
        nxt.col  = base.col + dc;
        nxt.row2 = base.row2 + dr;
    end

    assign row     = pos.row2 >>> 1;
    assign in_grid = (pos.col >= 0) && (pos.col < GRID_S) &&
                     (pos.row2 >= 0) && (row < GRID_S);
    assign addr    = ADDR_W'($unsigned(row)) * ADDR_W'(GRID_SIZE) +
                     ADDR_W'($unsigned(pos.col));

endmodule

>>> src/hex_disk_grid_painter_unit.sv
// Hex-map cell store of GRID_SIZE x GRID_SIZE type codes in offset coordinates
// (odd columns half a row lower), with one request port and one response port.
// After reset the grid is swept to zero, one cell per cycle, over all
// GRID_SIZE*GRID_SIZE cells (1024 by default); req.ready stays low meanwhile.
// A read is registered by the grid memory and then by the response register.
// A paint with R = min(radius, 32) (R of 0 counts as 1) visits 1 + 3*R*(R-1)
// candidate cells, one per cycle, through a single coordinate step unit and
// the one grid write port, up to 2977 cells; the response follows the last.
// One request is handled at a time: req.ready is low while a request is in
// work or while its response has not been taken.
module hex_disk_grid_painter_unit import hdgp_pkg::*; #(
    parameter int GRID_SIZE = 32,
    parameter int TYPE_BITS = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    hdgp_req_if.sink   req,
    hdgp_rsp_if.source rsp
);

    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    state_t                    state_reg,  state_next;
    coord_t                    pos_reg,    pos_next;
    logic signed [COORD_W-1:0] ctr_col_reg, ctr_col_next;
    logic signed [COORD_W-1:0] ring_row2_reg, ring_row2_next;
    logic [RAD_W-1:0]          ring_reg,   ring_next;
    logic [RAD_W-1:0]          k_reg,      k_next;
    side_t                     side_reg,   side_next;
    logic [RAD_W-1:0]          rad_reg,    rad_next;
    logic [TYPE_BITS-1:0]      type_reg,   type_next;
    logic [CNT_W-1:0]          count_reg,  count_next;
    logic [ADDR_W-1:0]         clr_addr_reg, clr_addr_next;
    logic                      rd_oob_reg, rd_oob_next;
    logic                      out_valid_reg, out_valid_next;
    logic [TYPE_IN_W-1:0]      out_value_reg, out_value_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;

    coord_t                    origin;
    coord_t                    step_nxt;
    step_ctl_t                 step_ctl;
    logic                      step_in_grid;
    logic [ADDR_W-1:0]         step_addr;

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [TYPE_BITS-1:0]      mem_wdata;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [TYPE_BITS-1:0]      mem_rdata;

    logic                      req_fire;
    logic                      rd_oob;
    logic [TYPE_BITS+TYPE_IN_W-1:0] type_wide;
    logic [TYPE_BITS+TYPE_IN_W-1:0] value_wide;
    logic                      last_k;
    logic                      ring_end;
    logic                      last_ring;

    assign req.ready     = (state_reg == ST_IDLE) && !out_valid_reg;
    assign req_fire      = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_value    = out_value_reg;
    assign rsp.cells_written = out_count_reg;

    assign type_wide  = {{TYPE_BITS{1'b0}}, req.cell_type};
    assign value_wide = {{TYPE_IN_W{1'b0}}, mem_rdata};

    assign rd_oob    = (int'(req.center_col) >= GRID_SIZE) ||
                       (int'(req.center_row) >= GRID_SIZE);
    assign mem_raddr = rd_oob ? '0 :
                       ADDR_W'(req.center_row) * ADDR_W'(GRID_SIZE) +
                       ADDR_W'(req.center_col);

    assign origin.col  = ctr_col_reg;
    assign origin.row2 = ring_row2_reg;

    assign last_k    = (k_reg == ring_reg - RAD_W'(1));
    assign ring_end  = (ring_reg == '0) || (last_k && (side_reg == SIDE_5));
    assign last_ring = ((ring_reg + RAD_W'(1)) >= rad_reg);

    assign step_ctl.restart = ring_end;
    assign step_ctl.side    = side_reg;

    hdgp_step_unit #(
        .GRID_SIZE (GRID_SIZE),
        .ADDR_W    (ADDR_W)
    ) u_step (
        .pos     (pos_reg),
        .origin  (origin),
        .ctl     (step_ctl),
        .nxt     (step_nxt),
        .in_grid (step_in_grid),
        .addr    (step_addr)
    );

    hdgp_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (TYPE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ctr_col_next   = ctr_col_reg;
        ring_row2_next = ring_row2_reg;
        ring_next      = ring_reg;
        k_next         = k_reg;
        side_next      = side_reg;
        rad_next       = rad_reg;
        type_next      = type_reg;
        count_next     = count_reg;
        clr_addr_next  = clr_addr_reg;
        rd_oob_next    = rd_oob_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = step_addr;
        mem_wdata      = type_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.mode == MODE_READ)
                    begin
                        rd_oob_next = rd_oob;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        ctr_col_next   = COORD_W'(req.center_col);
                        ring_row2_next = COORD_W'({req.center_row, req.center_col[0]});
                        pos_next.col   = COORD_W'(req.center_col);
                        pos_next.row2  = COORD_W'({req.center_row, req.center_col[0]});
                        rad_next       = (req.radius > RADIUS_MAX) ? RADIUS_MAX : req.radius;
                        type_next      = type_wide[TYPE_BITS-1:0];
                        ring_next      = '0;
                        k_next         = '0;
                        side_next      = SIDE_0;
                        count_next     = '0;
                        state_next     = ST_PAINT;
                    end
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_value_next = rd_oob_reg ? '0 : value_wide[TYPE_IN_W-1:0];
                out_count_next = '0;
                state_next     = ST_IDLE;
            end
            ST_PAINT:
            begin
                mem_we = step_in_grid;
                if (step_in_grid && (count_reg != COUNT_MAX))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                pos_next = step_nxt;
                if (ring_end)
                begin
                    if (last_ring)
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_count_next = count_next;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        ring_row2_next = step_nxt.row2;
                        ring_next      = ring_reg + RAD_W'(1);
                        k_next         = '0;
                        side_next      = SIDE_0;
                    end
                end
                else if (last_k)
                begin
                    k_next    = '0;
                    side_next = side_t'(side_reg + 3'd1);
                end
                else
                begin
                    k_next = k_reg + RAD_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            ring_reg      <= '0;
            k_reg         <= '0;
            side_reg      <= SIDE_0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            ring_reg      <= ring_next;
            k_reg         <= k_next;
            side_reg      <= side_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        ctr_col_reg   <= ctr_col_next;
        ring_row2_reg <= ring_row2_next;
        rad_reg       <= rad_next;
        type_reg      <= type_next;
        rd_oob_reg    <= rd_oob_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
    end

endmodule
